// ----- hdl/tea_pkg.sv -----
package tea_pkg;

  localparam logic [31:0] Delta = 32'h9E37_79B9;
  localparam int unsigned RoundsDefault = 32;
  localparam int unsigned AddrWidth = 4;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } tea_reg_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  typedef struct packed {
    logic vld;
    logic op;
  } tea_ctl_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

  // running sum after n rounds, modulo 2^32
  function automatic logic [31:0] tea_sum(input int unsigned n);
    logic [63:0] p;
    p = 64'(Delta) * 64'(n);
    return p[31:0];
  endfunction

endpackage

// ----- hdl/tea_round_stage.sv -----
module tea_round_stage #(
  parameter int unsigned STAGE  = 0,
  parameter int unsigned ROUNDS = tea_pkg::RoundsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tea_pkg::tea_key_t key,
  input  tea_pkg::tea_ctl_t ctl_in,
  input  logic [31:0]       w0_in,
  input  logic [31:0]       w1_in,
  output tea_pkg::tea_ctl_t ctl_out,
  output logic [31:0]       w0_out,
  output logic [31:0]       w1_out
);

  localparam int unsigned Round = STAGE / 2;
  localparam logic        Half  = 1'((STAGE % 2) == 1);
  localparam logic [31:0] EncSum = tea_pkg::tea_sum(Round + 1);
  localparam logic [31:0] DecSum = tea_pkg::tea_sum(ROUNDS - Round);

  logic        upd_w0;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] sum;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] m;
  logic [31:0] res;

  // encrypt: w0 then w1 each round; decrypt: w1 then w0
  always_comb begin
    upd_w0 = (ctl_in.op == Half);
    src    = upd_w0 ? w1_in : w0_in;
    tgt    = upd_w0 ? w0_in : w1_in;
    ka     = upd_w0 ? key.k0 : key.k2;
    kb     = upd_w0 ? key.k1 : key.k3;
    sum    = ctl_in.op ? DecSum : EncSum;
    m      = tea_pkg::tea_mix(src, sum, ka, kb);
    res    = ctl_in.op ? (tgt - m) : (tgt + m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_out.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl_out.op <= ctl_in.op;
      w0_out     <= upd_w0 ? res : w0_in;
      w1_out     <= upd_w0 ? w1_in : res;
    end
  end

endmodule

// ----- hdl/tea_block_cipher.sv -----
// TEA block cipher, 64-bit block, 128-bit key held in four 32-bit registers
// (key_word0..3 at byte addresses 0, 4, 8, 12). Each transfer carries op
// (0 encrypt, 1 decrypt) and the two block words; one result transfer
// follows per input. Every half-round is one register stage, so an item
// passes every stage, then the output register. A new block is taken
// every cycle unless the pipeline stalls. The output register frees the
// pipeline: it only stalls when a finished result waits and another one
// has reached the last stage. Keys must only be written while idle.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = tea_pkg::RoundsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tea_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [31:0]                   block_w0,
  input  logic [31:0]                   block_w1,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_w0,
  output logic [31:0]                   out_w1
);

  localparam int unsigned NumStages = 2 * ROUNDS;

  tea_pkg::tea_key_t key;
  tea_pkg::tea_reg_t reg_sel;
  logic              en;

  tea_pkg::tea_ctl_t ctl_s [0:NumStages];
  logic [31:0]       w0_s  [0:NumStages];
  logic [31:0]       w1_s  [0:NumStages];

  assign pready  = 1'b1;
  assign reg_sel = tea_pkg::tea_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        tea_pkg::REG_KEY0: key.k0 <= pwdata;
        tea_pkg::REG_KEY1: key.k1 <= pwdata;
        tea_pkg::REG_KEY2: key.k2 <= pwdata;
        tea_pkg::REG_KEY3: key.k3 <= pwdata;
        default: key <= key;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tea_pkg::REG_KEY0: prdata = key.k0;
      tea_pkg::REG_KEY1: prdata = key.k1;
      tea_pkg::REG_KEY2: prdata = key.k2;
      tea_pkg::REG_KEY3: prdata = key.k3;
      default:           prdata = '0;
    endcase
  end

  assign en       = !ctl_s[NumStages].vld || !out_valid || out_ready;
  assign in_ready = en;

  assign ctl_s[0].vld = in_valid;
  assign ctl_s[0].op  = op;
  assign w0_s[0]      = block_w0;
  assign w1_s[0]      = block_w1;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    tea_round_stage #(
      .STAGE (s),
      .ROUNDS(ROUNDS)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .key    (key),
      .ctl_in (ctl_s[s]),
      .w0_in  (w0_s[s]),
      .w1_in  (w1_s[s]),
      .ctl_out(ctl_s[s+1]),
      .w0_out (w0_s[s+1]),
      .w1_out (w1_s[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid <= ctl_s[NumStages].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_w0 <= w0_s[NumStages];
      out_w1 <= w1_s[NumStages];
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> ctl_s[1].vld)
    else $error("input transfer lost at first stage");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (ctl_s[NumStages].vld && out_valid && !out_ready) |=>
      (ctl_s[NumStages].vld && $stable(w0_s[NumStages]) && $stable(w1_s[NumStages])))
    else $error("last stage changed while output stalled");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");

endmodule
